### sv/rdc_pkg.sv
package rdc_pkg;

  localparam int VALUE_BITS  = 31;
  localparam int RADIX_BITS  = 8;
  localparam int COUNT_BITS  = 5;
  localparam int MAX_RESULTS = 31;
  localparam int STEP_BITS   = $clog2(VALUE_BITS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_PUSH
  } rdc_state_t;

endpackage

### sv/rdc_div.sv
module rdc_div import rdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [RADIX_BITS-1:0] divisor,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [RADIX_BITS-1:0] remainder,
  output logic                  done
);

  logic [VALUE_BITS-1:0] q;
  logic [RADIX_BITS-1:0] r;
  logic [STEP_BITS-1:0]  steps;
  logic                  busy;
  logic [RADIX_BITS:0]   trial;
  logic [RADIX_BITS:0]   diff;
  logic                  fits;

  // shift in one dividend bit, subtract the divisor when it fits
  always_comb begin
    trial = {r, q[VALUE_BITS-1]};
    diff  = trial - {1'b0, divisor};
    fits  = (trial >= {1'b0, divisor});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_BITS'(VALUE_BITS);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q <= dividend;
      r <= '0;
    end else if (busy) begin
      q <= {q[VALUE_BITS-2:0], fits};
      r <= fits ? diff[RADIX_BITS-1:0] : trial[RADIX_BITS-1:0];
    end
  end

  assign quotient  = q;
  assign remainder = r;

endmodule

### sv/radix_digit_converter_top.sv
// Converts a non-negative integer to its digits in a base from 2 to 255, least significant
// digit first, one result per digit with a running count and a last mark. A zero value gives
// one result with empty_res set; a radix below 2 gives one result with bad_radix set. One
// request is worked at a time. Each digit comes from a restoring divider that produces one
// quotient bit per cycle; the division for the next digit starts only when the previous digit
// is loaded into the output registers, so an output stall holds the request.
module radix_digit_converter_top import rdc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [VALUE_BITS-1:0] value,
  input  logic [RADIX_BITS-1:0] radix,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [RADIX_BITS-1:0] digit,
  output logic [COUNT_BITS-1:0] digit_count,
  output logic                  is_last,
  output logic                  empty_res,
  output logic                  bad_radix
);

  rdc_state_t state, state_next;

  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] value_hold;
  logic [RADIX_BITS-1:0] radix_hold;
  logic [VALUE_BITS-1:0] div_dividend;
  logic [VALUE_BITS-1:0] quotient;
  logic [RADIX_BITS-1:0] remainder;
  logic [COUNT_BITS-1:0] count;
  logic [COUNT_BITS-1:0] count_next;
  logic [RADIX_BITS-1:0] p_digit;
  logic                  p_last;
  logic                  p_empty;
  logic                  p_bad;
  logic                  radix_low;
  logic                  value_zero;
  logic                  out_free;
  logic                  load_out;
  logic                  in_take;

  assign radix_low  = (radix_hold < RADIX_BITS'(2));
  assign value_zero = (value_hold == '0);
  assign out_free   = !out_valid || !out_stall;
  assign in_take    = in_valid && !in_stall;
  assign count_next = count + 1'b1;
  assign div_dividend = (state == S_CHECK) ? value_hold : quotient;

  rdc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (radix_hold),
    .quotient  (quotient),
    .remainder (remainder),
    .done      (div_done)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_CHECK;
      S_CHECK: state_next = (radix_low || value_zero) ? S_PUSH : S_DIV;
      S_DIV:   if (div_done) state_next = S_PUSH;
      S_PUSH: begin
        if (out_free) state_next = p_last ? S_IDLE : S_DIV;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall  = 1'b1;
    load_out  = 1'b0;
    div_start = 1'b0;
    case (state)
      S_IDLE:  in_stall = 1'b0;
      S_CHECK: div_start = !(radix_low || value_zero);
      S_DIV:   ;
      S_PUSH: begin
        load_out  = out_free;
        div_start = out_free && !p_last;
      end
      default: in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      value_hold <= value;
      radix_hold <= radix;
    end
    if (state == S_CHECK) begin
      count   <= '0;
      p_digit <= '0;
      p_last  <= 1'b1;
      p_bad   <= radix_low;
      p_empty <= !radix_low && value_zero;
    end else if (state == S_DIV && div_done) begin
      count   <= count_next;
      p_digit <= remainder;
      p_last  <= (quotient == '0) || (count_next == COUNT_BITS'(MAX_RESULTS));
      p_bad   <= 1'b0;
      p_empty <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      digit       <= p_digit;
      digit_count <= count;
      is_last     <= p_last;
      empty_res   <= p_empty;
      bad_radix   <= p_bad;
    end
  end

`ifndef SYNTHESIS
  a_flag_single : assert property (@(posedge clk) disable iff (rst)
    out_valid && (bad_radix || empty_res) |-> is_last && digit_count == '0 && digit == '0)
    else $error("flagged result is not a single empty result");

  a_digit_range : assert property (@(posedge clk) disable iff (rst)
    state == S_DIV && div_done |-> remainder < radix_hold)
    else $error("remainder not below radix");

  a_more_digits : assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_last |-> state != S_IDLE)
    else $error("request dropped before its last digit");

  a_no_double_flag : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(bad_radix && empty_res))
    else $error("both bad_radix and empty_res set");
`endif

endmodule

### verif/tb_radix_digit_converter_top.sv
module tb_radix_digit_converter_top;
  import rdc_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic [RADIX_BITS-1:0] digit;
    logic [COUNT_BITS-1:0] count;
    logic                  last;
    logic                  empty;
    logic                  bad;
  } digit_item_t;

  class digit_tracker;
    digit_item_t expected_digits[$];
    int          errors;

    function void note_request(input logic [VALUE_BITS-1:0] v_in,
                               input logic [RADIX_BITS-1:0] r_in);
      longint unsigned v;
      longint unsigned base;
      int              n;
      digit_item_t     d;
      v = v_in;
      base = r_in;
      n = 0;
      d = '0;
      if (base < 2) begin
        d.last = 1'b1;
        d.bad = 1'b1;
        expected_digits.push_back(d);
        return;
      end
      if (v == 0) begin
        d.last = 1'b1;
        d.empty = 1'b1;
        expected_digits.push_back(d);
        return;
      end
      while (v != 0 && n < MAX_RESULTS) begin
        d = '0;
        d.digit = RADIX_BITS'(v % base);
        v = v / base;
        d.count = COUNT_BITS'(n + 1);
        d.last = (v == 0) || (n + 1 == MAX_RESULTS);
        expected_digits.push_back(d);
        n++;
      end
    endfunction

    function void check_digit(input digit_item_t got);
      digit_item_t want;
      if (expected_digits.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected digit: digit=%0d count=%0d last=%0b empty=%0b bad=%0b",
                   got.digit, got.count, got.last, got.empty, got.bad);
        return;
      end
      want = expected_digits.pop_front();
      if (got.digit !== want.digit || got.count !== want.count || got.last !== want.last ||
          got.empty !== want.empty || got.bad !== want.bad) begin
        errors++;
        if (errors <= 10)
          $display("digit mismatch: exp %0d/%0d/%0b/%0b/%0b got %0d/%0d/%0b/%0b/%0b",
                   want.digit, want.count, want.last, want.empty, want.bad,
                   got.digit, got.count, got.last, got.empty, got.bad);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [VALUE_BITS-1:0] value = '0;
  logic [RADIX_BITS-1:0] radix = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [RADIX_BITS-1:0] digit;
  logic [COUNT_BITS-1:0] digit_count;
  logic                  is_last;
  logic                  empty_res;
  logic                  bad_radix;

  digit_tracker tracker = new();
  int           send_idle_pct = 15;
  int           recv_stall_pct = 73;
  int           idle_cycles = 0;

  radix_digit_converter_top u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .radix      (radix),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit      (digit),
    .digit_count(digit_count),
    .is_last    (is_last),
    .empty_res  (empty_res),
    .bad_radix  (bad_radix)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      if (out_valid && !out_stall)
        tracker.check_digit({digit, digit_count, is_last, empty_res, bad_radix});
      if ((out_valid && !out_stall) || (in_valid && !in_stall))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  task automatic send_request(input logic [VALUE_BITS-1:0] v, input logic [RADIX_BITS-1:0] r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    radix <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tracker.note_request(v, r);
  endtask

  task automatic send_random(input int count);
    logic [VALUE_BITS-1:0] v;
    logic [RADIX_BITS-1:0] r;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0:       v = VALUE_BITS'($urandom_range(0, 1000));
        1, 2:    v = VALUE_BITS'($urandom() >> $urandom_range(0, 31));
        3:       v = '0;
        default: v = VALUE_BITS'($urandom());
      endcase
      case ($urandom_range(0, 11))
        0:          r = RADIX_BITS'($urandom_range(0, 1));
        1, 2, 3:    r = RADIX_BITS'($urandom_range(2, 16));
        default:    r = RADIX_BITS'($urandom_range(2, 255));
      endcase
      send_request(v, r);
    end
  endtask

  initial begin
    wait (idle_cycles >= STALL_LIMIT);
    $display("radix_digit_converter_top verification failed");
    $finish;
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_request('0, 8'd10);
    send_request('0, 8'd0);
    send_request(31'd123, 8'd0);
    send_request('1, 8'd1);
    send_request('0, 8'd1);
    send_request('1, 8'd2);
    send_request('1, 8'd255);
    send_request('1, 8'd3);
    send_request('1, 8'd254);
    send_request(31'd1, 8'd2);
    send_request(31'd9, 8'd10);
    send_request(31'd10, 8'd10);
    send_request(31'd254, 8'd255);
    send_request(31'd255, 8'd255);
    send_request(31'h5555_5555, 8'd16);
    send_request(31'h2AAA_AAAA, 8'd128);
    send_request(31'h4000_0000, 8'd2);
    send_request(31'd1, 8'd7);
    send_request(31'd12345678, 8'd200);
    send_request(31'd65535, 8'd170);

    send_random(47);
    send_idle_pct = 73;
    recv_stall_pct = 15;
    send_random(47);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(46);
    in_valid <= 1'b0;

    while (tracker.expected_digits.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.expected_digits.size() == 0)
      $display("radix_digit_converter_top verification clean");
    else
      $display("radix_digit_converter_top verification failed");
    $finish;
  end

endmodule
